// ===== hdl/cfcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfcc_pkg
// Shared widths, stage counts and the context word carried down the pipeline
// of the contact force unit.
// ----------------------------------------------------------------------------
package cfcc_pkg;

   localparam int DATA_W    = 32;   // force, displacement and indentation fields
   localparam int COEF_W    = 31;   // stiffness and friction tangent fields
   localparam int SQ_STEPS  = 32;   // one root bit per stage
   localparam int DIV_STEPS = 32;   // one quotient bit per stage
   localparam int REQ_W     = 288;  // 286 payload bits padded to whole bytes
   localparam int RSP_W     = 104;  // 98 payload bits padded to whole bytes

   typedef struct packed {
      logic signed [DATA_W-1:0] fn;
      logic signed [DATA_W-1:0] ta;
      logic signed [DATA_W-1:0] tb;
      logic [DATA_W-1:0]        lim_lo;    // Coulomb limit, low word
      logic                     lim_fits;  // limit fits in the low word
      logic                     intact;
      logic                     slide;
   } ctx_type;

endpackage

// ===== hdl/contact_force_coulomb_clamp_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contact_force_coulomb_clamp_top
// Linear spring contact with a Coulomb friction clamp, one contact per word.
// ----------------------------------------------------------------------------
// Usage
//   req_* carries one contact per word: previous tangential forces, tangential
//   displacement increments, stiffnesses, indentation, friction tangents and
//   the intact and sliding flags. rsp_* returns one word per contact: normal
//   force, new tangential forces, sliding flag and the criterion flag.
//   Throughput: one word per cycle, sustained while rsp_tready is high, for any mix of contacts.
//   Depth: the shear root (one root bit per stage, 32 stages) and the clamp
//   division (one quotient bit per stage, 32 stages), plus the multiply,
//   rounding, squaring, summing and clamp decision stages and the output
//   register.
//   All stages advance together; when the receiver stalls with a word held
//   at the output, the whole pipe holds, bubbles included, and req_tready
//   falls in the same cycle, so nothing is dropped or repeated. Words keep
//   entering whenever the output register is empty or being taken.
//   Reset (synchronous, active high) clears every stage valid bit; payload
//   registers are not reset.
// ----------------------------------------------------------------------------
module contact_force_coulomb_clamp_top
   import cfcc_pkg::*;
#(
   parameter int FIXED_WIDTH   = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   // tdata, lowest bit up: prev_tangential_a[31:0], prev_tangential_b[63:32],
   // delta_disp_a[95:64], delta_disp_b[127:96], normal_stiffness[158:128],
   // shear_stiffness[189:159], indentation[221:190], friction_tan_self[252:222],
   // friction_tan_other[283:253], contact_intact[284], sliding_before[285], zeros
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             req_tvalid,
   output logic             req_tready,
   // tdata, lowest bit up: normal_elastic[31:0], tangential_force_a[63:32],
   // tangential_force_b[95:64], sliding_after[96], criterion_evaluated[97], zeros
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready
);

   localparam int STAGES = 4 + SQ_STEPS + 1 + DIV_STEPS + 1;
   localparam logic signed [63:0] SAT_MAX = (64'sd1 <<< (FIXED_WIDTH - 1)) - 64'sd1;
   localparam logic signed [63:0] SAT_MIN = -SAT_MAX - 64'sd1;
   localparam logic signed [63:0] HALF    = 64'sd1 <<< (FRACTION_BITS - 1);

   function automatic logic signed [DATA_W-1:0] sat_fx(input logic signed [63:0] v);
      logic signed [63:0] r;
      if (v > SAT_MAX) r = SAT_MAX;
      else if (v < SAT_MIN) r = SAT_MIN;
      else r = v;
      return r[DATA_W-1:0];
   endfunction

   function automatic logic signed [63:0] round_fx(input logic signed [63:0] p);
      logic signed [63:0] s;
      s = p + HALF;
      return s >>> FRACTION_BITS;
   endfunction

   // Global advance: hold every stage while the output word waits.
   logic adv;
   logic vld_ff [STAGES];
   assign adv        = rsp_tready | ~vld_ff[STAGES-1];
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAGES; i++) vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i < STAGES; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // ---- stage 1: spring products and mean friction tangent ----------------
   logic signed [63:0]       s1_pn_ff, s1_pta_ff, s1_ptb_ff;
   logic [COEF_W-1:0]        s1_mu_ff;
   logic signed [DATA_W-1:0] s1_pa_ff, s1_pb_ff;
   logic                     s1_intact_ff, s1_slide_ff;
   logic [DATA_W-1:0]        mu_sum;

   assign mu_sum = {1'b0, req_tdata[252:222]} + {1'b0, req_tdata[283:253]};

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_pn_ff     <= $signed({1'b0, req_tdata[158:128]}) * $signed(req_tdata[221:190]);
         s1_pta_ff    <= $signed({1'b0, req_tdata[189:159]}) * $signed(req_tdata[95:64]);
         s1_ptb_ff    <= $signed({1'b0, req_tdata[189:159]}) * $signed(req_tdata[127:96]);
         s1_mu_ff     <= mu_sum[DATA_W-1:1];
         s1_pa_ff     <= req_tdata[31:0];
         s1_pb_ff     <= req_tdata[63:32];
         s1_intact_ff <= req_tdata[284];
         s1_slide_ff  <= req_tdata[285];
      end
   end

   // ---- stage 2: round, subtract and saturate -----------------------------
   logic signed [DATA_W-1:0] s2_fn_ff, s2_ta_ff, s2_tb_ff;
   logic [COEF_W-1:0]        s2_mu_ff;
   logic                     s2_intact_ff, s2_slide_ff;
   logic signed [63:0]       pa_ext, pb_ext;

   assign pa_ext = {{(64-DATA_W){s1_pa_ff[DATA_W-1]}}, s1_pa_ff};
   assign pb_ext = {{(64-DATA_W){s1_pb_ff[DATA_W-1]}}, s1_pb_ff};

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_fn_ff     <= sat_fx(round_fx(s1_pn_ff));
         s2_ta_ff     <= s1_intact_ff ? sat_fx(pa_ext - round_fx(s1_pta_ff)) : sat_fx(pa_ext);
         s2_tb_ff     <= s1_intact_ff ? sat_fx(pb_ext - round_fx(s1_ptb_ff)) : sat_fx(pb_ext);
         s2_mu_ff     <= s1_mu_ff;
         s2_intact_ff <= s1_intact_ff;
         s2_slide_ff  <= s1_slide_ff;
      end
   end

   // ---- stage 3: squares and raw Coulomb limit ----------------------------
   logic signed [63:0] s3_sqa_ff, s3_sqb_ff, s3_limp_ff;
   ctx_type            s3_ctx_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_sqa_ff         <= s2_ta_ff * s2_ta_ff;
         s3_sqb_ff         <= s2_tb_ff * s2_tb_ff;
         s3_limp_ff        <= $signed({1'b0, s2_mu_ff}) * s2_fn_ff;
         s3_ctx_ff.fn       <= s2_fn_ff;
         s3_ctx_ff.ta       <= s2_ta_ff;
         s3_ctx_ff.tb       <= s2_tb_ff;
         s3_ctx_ff.lim_lo   <= '0;
         s3_ctx_ff.lim_fits <= 1'b0;
         s3_ctx_ff.intact   <= s2_intact_ff;
         s3_ctx_ff.slide    <= s2_slide_ff;
      end
   end

   // ---- stage 4: sum of squares, rounded limit floored at zero ------------
   logic signed [63:0] lim_r;
   ctx_type            s4_ctx;

   assign lim_r = round_fx(s3_limp_ff);

   always_comb begin
      s4_ctx = s3_ctx_ff;
      if (lim_r[63]) begin
         s4_ctx.lim_lo   = '0;
         s4_ctx.lim_fits = 1'b1;
      end else begin
         s4_ctx.lim_lo   = lim_r[DATA_W-1:0];
         s4_ctx.lim_fits = (lim_r[63:DATA_W] == '0);
      end
   end

   // ---- shear root: one bit per stage --------------------------------------
   logic [63:0]       sq_n_ff    [SQ_STEPS+1];
   logic [35:0]       sq_rem_ff  [SQ_STEPS+1];
   logic [31:0]       sq_root_ff [SQ_STEPS+1];
   ctx_type           sq_ctx_ff  [SQ_STEPS+1];
   logic [63:0]       sq_n_in    [SQ_STEPS];
   logic [35:0]       sq_rem_in  [SQ_STEPS];
   logic [31:0]       sq_root_in [SQ_STEPS];

   always_comb begin
      for (int k = 0; k < SQ_STEPS; k++) begin
         logic [35:0] rem_pre;
         logic [35:0] trial;
         rem_pre = {sq_rem_ff[k][33:0], sq_n_ff[k][63:62]};
         trial   = {2'b00, sq_root_ff[k], 2'b01};
         sq_n_in[k] = {sq_n_ff[k][61:0], 2'b00};
         if (rem_pre >= trial) begin
            sq_rem_in[k]  = rem_pre - trial;
            sq_root_in[k] = {sq_root_ff[k][30:0], 1'b1};
         end else begin
            sq_rem_in[k]  = rem_pre;
            sq_root_in[k] = {sq_root_ff[k][30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_n_ff[0]    <= s3_sqa_ff + s3_sqb_ff;
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
         sq_ctx_ff[0]  <= s4_ctx;
         for (int k = 0; k < SQ_STEPS; k++) begin
            sq_n_ff[k+1]    <= sq_n_in[k];
            sq_rem_ff[k+1]  <= sq_rem_in[k];
            sq_root_ff[k+1] <= sq_root_in[k];
            sq_ctx_ff[k+1]  <= sq_ctx_ff[k];
         end
      end
   end

   // ---- clamp decision and division numerators ----------------------------
   logic [31:0] shear;
   ctx_type     sc;
   logic        clamp_in;
   logic [31:0] mag_a, mag_b;
   logic [63:0] num_a, num_b;

   assign shear    = sq_root_ff[SQ_STEPS];
   assign sc       = sq_ctx_ff[SQ_STEPS];
   assign clamp_in = sc.intact && (shear != '0) && sc.lim_fits && (sc.lim_lo < shear);
   assign mag_a    = sc.ta[DATA_W-1] ? -sc.ta : sc.ta;
   assign mag_b    = sc.tb[DATA_W-1] ? -sc.tb : sc.tb;
   assign num_a    = mag_a * sc.lim_lo;
   assign num_b    = mag_b * sc.lim_lo;

   // ---- clamp division: one quotient bit per stage, two lanes -------------
   logic [31:0] dv_rem_a_ff [DIV_STEPS+1], dv_lo_a_ff [DIV_STEPS+1], dv_q_a_ff [DIV_STEPS+1];
   logic [31:0] dv_rem_b_ff [DIV_STEPS+1], dv_lo_b_ff [DIV_STEPS+1], dv_q_b_ff [DIV_STEPS+1];
   logic [31:0] dv_den_ff   [DIV_STEPS+1];
   logic        dv_clamp_ff [DIV_STEPS+1];
   ctx_type     dv_ctx_ff   [DIV_STEPS+1];
   logic [31:0] dv_rem_a_in [DIV_STEPS], dv_q_a_in [DIV_STEPS];
   logic [31:0] dv_rem_b_in [DIV_STEPS], dv_q_b_in [DIV_STEPS];

   always_comb begin
      for (int k = 0; k < DIV_STEPS; k++) begin
         logic [32:0] ra, rb, den;
         logic [32:0] da, db;
         den = {1'b0, dv_den_ff[k]};
         ra  = {dv_rem_a_ff[k], dv_lo_a_ff[k][31]};
         rb  = {dv_rem_b_ff[k], dv_lo_b_ff[k][31]};
         da  = (ra >= den) ? ra - den : ra;
         db  = (rb >= den) ? rb - den : rb;
         dv_rem_a_in[k] = da[31:0];
         dv_rem_b_in[k] = db[31:0];
         dv_q_a_in[k]   = {dv_q_a_ff[k][30:0], (ra >= den)};
         dv_q_b_in[k]   = {dv_q_b_ff[k][30:0], (rb >= den)};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_rem_a_ff[0] <= num_a[63:32];
         dv_lo_a_ff[0]  <= num_a[31:0];
         dv_q_a_ff[0]   <= '0;
         dv_rem_b_ff[0] <= num_b[63:32];
         dv_lo_b_ff[0]  <= num_b[31:0];
         dv_q_b_ff[0]   <= '0;
         dv_den_ff[0]   <= shear;
         dv_clamp_ff[0] <= clamp_in;
         dv_ctx_ff[0]   <= sc;
         for (int k = 0; k < DIV_STEPS; k++) begin
            dv_rem_a_ff[k+1] <= dv_rem_a_in[k];
            dv_lo_a_ff[k+1]  <= {dv_lo_a_ff[k][30:0], 1'b0};
            dv_q_a_ff[k+1]   <= dv_q_a_in[k];
            dv_rem_b_ff[k+1] <= dv_rem_b_in[k];
            dv_lo_b_ff[k+1]  <= {dv_lo_b_ff[k][30:0], 1'b0};
            dv_q_b_ff[k+1]   <= dv_q_b_in[k];
            dv_den_ff[k+1]   <= dv_den_ff[k];
            dv_clamp_ff[k+1] <= dv_clamp_ff[k];
            dv_ctx_ff[k+1]   <= dv_ctx_ff[k];
         end
      end
   end

   // ---- output register: restore signs of clamped components --------------
   ctx_type                  dc;
   logic                     dclamp;
   logic [31:0]              qa, qb;
   logic signed [DATA_W-1:0] out_fn_ff, out_ta_ff, out_tb_ff;
   logic                     out_slide_ff, out_crit_ff, out_clamp_ff;

   assign dc     = dv_ctx_ff[DIV_STEPS];
   assign dclamp = dv_clamp_ff[DIV_STEPS];
   assign qa     = dv_q_a_ff[DIV_STEPS];
   assign qb     = dv_q_b_ff[DIV_STEPS];

   always_ff @(posedge clock) begin
      if (adv) begin
         out_fn_ff    <= dc.fn;
         out_ta_ff    <= dclamp ? (dc.ta[DATA_W-1] ? -qa : qa) : dc.ta;
         out_tb_ff    <= dclamp ? (dc.tb[DATA_W-1] ? -qb : qb) : dc.tb;
         out_slide_ff <= dc.slide | dclamp;
         out_crit_ff  <= dc.intact;
         out_clamp_ff <= dclamp;
      end
   end

   assign rsp_tdata = {6'b0, out_crit_ff, out_slide_ff, out_tb_ff, out_ta_ff, out_fn_ff};

`ifndef SYNTHESIS
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> vld_ff[0])
      else $error("accepted word did not enter the pipe");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled output word changed");
   a_clamp_slides: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_clamp_ff) |-> (out_slide_ff && out_crit_ff))
      else $error("clamped contact not marked sliding");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");
`endif

endmodule
